/* hw/rtl/utf8v_pkg.sv */
`timescale 1ns / 1ps

package utf8v_pkg;

    // Verdict codes, also the sticky first-error latch
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_ENCODING  = 2'd1,
        ERR_FORBIDDEN = 2'd2,
        ERR_TRUNCATED = 2'd3
    } t_err;

    // Range rule for the first continuation byte after a lead byte
    typedef enum logic [2:0] {
        RULE_NONE = 3'd0,  // 80..BF
        RULE_E0   = 3'd1,  // A0..BF, no overlong 3-byte forms
        RULE_ED   = 3'd2,  // 80..9F, no surrogates
        RULE_F0   = 3'd3,  // 90..BF, no overlong 4-byte forms
        RULE_F4   = 3'd4,  // 80..8F, nothing above U+10FFFF
        RULE_C2   = 3'd5   // 80..9F after C2 is a C1 control
    } t_rule;

    localparam int          DATA_W      = 8;
    localparam int          PEND_W      = 2;

    localparam logic [7:0]  B_NUL       = 8'h00;
    localparam logic [7:0]  B_C0_MAX    = 8'h1f;
    localparam logic [7:0]  B_DEL       = 8'h7f;
    localparam logic [7:0]  B_LEAD2_MIN = 8'hc2;
    localparam logic [7:0]  B_LEAD2_MAX = 8'hdf;
    localparam logic [7:0]  B_LEAD3_MIN = 8'he0;
    localparam logic [7:0]  B_LEAD3_MAX = 8'hef;
    localparam logic [7:0]  B_LEAD_ED   = 8'hed;
    localparam logic [7:0]  B_LEAD4_MIN = 8'hf0;
    localparam logic [7:0]  B_LEAD4_MAX = 8'hf4;
    localparam logic [7:0]  B_CONT_MASK = 8'hc0;
    localparam logic [7:0]  B_CONT_TAG  = 8'h80;
    localparam logic [7:0]  B_C1_MAX    = 8'h9f;
    localparam logic [7:0]  B_E0_MIN    = 8'ha0;
    localparam logic [7:0]  B_F0_MIN    = 8'h90;

endpackage

/* hw/rtl/utf8_stream_validator.sv */
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                tuser (low bit up)           tlast
// s_axis    in   [7:0] data_byte                   [0] has_byte,                last
//                                                  [1] strict_ctrl
// m_axis    out  [0] valid_res, [2:1] error_kind,  -                            -
//                [7:3] zero
//
// One item per cycle. The byte check and state update are a single level of
// logic between the scan state registers and the output register.
// A verdict appears on m_axis the cycle after the item with tlast is taken.
// i_rst_n (sync, active low) clears the scan state and the output valid.
// While a verdict is held and m_axis_tready is low, every input item stalls;
// s_axis_tready = !m_axis_tvalid || m_axis_tready.

module utf8_stream_validator
    import utf8v_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last
    input  logic [1:0]  s_axis_tuser,   // [0] has_byte, [1] strict_ctrl
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] valid_res, [2:1] error_kind, [7:3] zero
);

    // scan state
    logic [PEND_W-1:0] r_pend, n_pend;
    t_rule             r_rule, n_rule;
    t_err              r_first, n_first;

    // output register
    logic              r_out_valid;
    t_err              r_out_err;

    logic              w_acc;
    logic [DATA_W-1:0] w_byte;
    logic              w_has;
    logic              w_rc;
    t_err              w_err;
    t_err              w_verdict;

    assign w_byte = s_axis_tdata;
    assign w_has  = s_axis_tuser[0];
    assign w_rc   = s_axis_tuser[1];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_pend = r_pend;
        n_rule = r_rule;
        w_err  = ERR_NONE;
        if (w_has) begin
            if (r_pend == '0) begin
                // expecting a lead byte or ASCII
                if (w_byte <= B_DEL) begin
                    if (w_byte == B_NUL) begin
                        w_err = ERR_FORBIDDEN;
                    end else if (w_rc && (w_byte <= B_C0_MAX || w_byte == B_DEL)) begin
                        w_err = ERR_FORBIDDEN;
                    end
                end else if (w_byte >= B_LEAD2_MIN && w_byte <= B_LEAD2_MAX) begin
                    n_pend = PEND_W'(1);
                    n_rule = (w_byte == B_LEAD2_MIN) ? RULE_C2 : RULE_NONE;
                end else if (w_byte >= B_LEAD3_MIN && w_byte <= B_LEAD3_MAX) begin
                    n_pend = PEND_W'(2);
                    n_rule = (w_byte == B_LEAD3_MIN) ? RULE_E0 :
                             (w_byte == B_LEAD_ED)   ? RULE_ED : RULE_NONE;
                end else if (w_byte >= B_LEAD4_MIN && w_byte <= B_LEAD4_MAX) begin
                    n_pend = PEND_W'(3);
                    n_rule = (w_byte == B_LEAD4_MIN) ? RULE_F0 :
                             (w_byte == B_LEAD4_MAX) ? RULE_F4 : RULE_NONE;
                end else begin
                    w_err = ERR_ENCODING;
                end
            end else begin
                // expecting a continuation byte
                n_rule = RULE_NONE;
                if ((w_byte & B_CONT_MASK) != B_CONT_TAG) begin
                    // not taken as a new lead byte; sequence is dropped
                    n_pend = '0;
                    w_err  = ERR_ENCODING;
                end else begin
                    n_pend = r_pend - PEND_W'(1);
                    unique case (r_rule)
                        RULE_E0: if (w_byte <  B_E0_MIN) w_err = ERR_ENCODING;
                        RULE_ED: if (w_byte >= B_E0_MIN) w_err = ERR_ENCODING;
                        RULE_F0: if (w_byte <  B_F0_MIN) w_err = ERR_ENCODING;
                        RULE_F4: if (w_byte >= B_F0_MIN) w_err = ERR_ENCODING;
                        RULE_C2: if (w_rc && w_byte <= B_C1_MAX) w_err = ERR_FORBIDDEN;
                        default: w_err = ERR_NONE;
                    endcase
                end
            end
        end
        // first error wins
        n_first   = (r_first == ERR_NONE) ? w_err : r_first;
        w_verdict = (n_first == ERR_NONE && n_pend != '0) ? ERR_TRUNCATED : n_first;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_rule  <= RULE_NONE;
            r_first <= ERR_NONE;
        end else if (w_acc) begin
            if (s_axis_tlast) begin
                r_pend  <= '0;
                r_rule  <= RULE_NONE;
                r_first <= ERR_NONE;
            end else begin
                r_pend  <= n_pend;
                r_rule  <= n_rule;
                r_first <= n_first;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc && s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && s_axis_tlast) begin
            r_out_err <= w_verdict;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_err, (r_out_err == ERR_NONE)};

`ifndef ASSERT_OFF
    // no range rule survives once the sequence is closed
    a_rule_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend == '0 |-> r_rule == RULE_NONE)
        else $error("range rule set with no pending continuation");

    // end of string clears the scan state
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && s_axis_tlast |=> r_pend == '0 && r_first == ERR_NONE)
        else $error("scan state not cleared after end of string");

    // an error, once latched, holds until the end of the string
    a_sticky_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !s_axis_tlast && r_first != ERR_NONE |=> r_first == $past(r_first))
        else $error("latched error changed inside a string");

    // an item without a byte and without last leaves the state alone
    a_empty_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !s_axis_tlast && !w_has |=> $stable(r_pend) && $stable(r_first))
        else $error("item without byte changed the scan state");

    // a verdict only follows an accepted tlast item
    a_verdict_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_acc && s_axis_tlast))
        else $error("verdict without a terminating item");
`endif

endmodule
